// File: src/ihpp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ihpp_pkg;

	// Default width of the byte position counter.
	localparam int POSITION_BITS_DEF = 32;
	// Depth of the queue between the byte classifier and the parser.
	localparam int MID_DEPTH_DEF = 4;
	// Depth of the result queue.
	localparam int RES_DEPTH = 2;

	// File magic, stored little-endian in the first two bytes.
	localparam logic [15:0] MAGIC = 16'hC6F5;
	localparam logic [7:0] MAGIC_LO = MAGIC[7:0];
	localparam logic [7:0] MAGIC_HI = MAGIC[15:8];

	// Type byte that introduces a keyed property, and the key terminator.
	localparam logic [7:0] TYPE_KEYED = 8'h01;
	localparam logic [7:0] KEY_NUL = 8'h00;

	// Result status codes.
	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_BAD_MAGIC = 2'd1;
	localparam logic [1:0] ST_BEYOND = 2'd2;
	localparam logic [1:0] ST_SHORT = 2'd3;

	// Matched key codes: key table index plus one.
	localparam logic [2:0] KEY_NONE = 3'd0;
	localparam logic [2:0] KEY_HEIGHT = 3'd1;
	localparam logic [2:0] KEY_WIDTH = 3'd2;
	localparam logic [2:0] KEY_COMP_FORMAT = 3'd3;
	localparam logic [2:0] KEY_SIZE = 3'd4;
	localparam logic [2:0] KEY_FORMAT = 3'd5;
	localparam logic [2:0] KEY_TYPE = 3'd6;

	localparam int KEY_COUNT = 6;
	localparam logic [4:0] KEY_IDX_MAX = 5'd31;

	localparam logic [4:0] KEY_LEN [KEY_COUNT] = '{5'd6, 5'd5, 5'd16, 5'd4, 5'd6, 5'd4};

	localparam logic [7:0] KEY_TEXT [KEY_COUNT][16] = '{
		'{"h", "e", "i", "g", "h", "t", 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"w", "i", "d", "t", "h", 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"c", "o", "m", "p", "r", "e", "s", "s",
		  "e", "d", "F", "o", "r", "m", "a", "t"},
		'{"s", "i", "z", "e", 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"f", "o", "r", "m", "a", "t", 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"t", "y", "p", "e", 8'h00, 8'h00, 8'h00, 8'h00,
		  8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	// Parser phases.
	typedef enum logic [2:0] {
		PH_MAGIC,
		PH_OFFSET,
		PH_TYPE,
		PH_KEY,
		PH_VALUE,
		PH_SKIP
	} phase_t;

	typedef struct packed {
		logic [7:0] file_byte;
		logic       last;
	} in_t;

	typedef struct packed {
		logic [1:0]         status;
		logic signed [31:0] image_width;
		logic signed [31:0] image_height;
		logic signed [31:0] pixel_format;
		logic               is_compressed;
		logic signed [31:0] compressed_size;
		logic signed [31:0] component_type;
		logic [31:0]        data_offset;
		logic [31:0]        data_size;
	} out_t;

	// Byte as classified by its position in the file.
	typedef struct packed {
		logic [7:0] file_byte;
		logic       last;
		logic       pos_zero;   // first byte of the file
		logic       pre_valid;  // one of the eight offset bytes
		logic [2:0] pre_idx;    // byte lane within the offset
		logic       pre_end;    // last offset byte or later
		logic       short_file; // file would be shorter than the preheader
	} tag_t;

endpackage

`default_nettype wire

// File: src/ihpp_fifo.sv
`timescale 1ns / 1ps
`default_nettype none

module ihpp_fifo #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             push,
	output logic                  full,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic             pop,
	output logic                  empty,
	output logic      [WIDTH-1:0] rd_data
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             do_push;
	logic             do_pop;

	assign full    = (cnt_q == CNT_W'(DEPTH));
	assign empty   = (cnt_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({do_push, do_pop})
				2'b10: begin
					cnt_q <= cnt_q + 1'b1;
				end
				2'b01: begin
					cnt_q <= cnt_q - 1'b1;
				end
				default: begin
					cnt_q <= cnt_q;
				end
			endcase
		end
	end

endmodule

`default_nettype wire

// File: src/ihpp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ihpp_front #(
	parameter int POSITION_BITS = ihpp_pkg::POSITION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     push,
	output logic                          full,
	input  wire ihpp_pkg::in_t            item,
	input  wire logic                     mid_full,
	output logic                          mid_push,
	output ihpp_pkg::tag_t                mid_tag,
	output logic [POSITION_BITS-1:0]      mid_pos
);

	logic [POSITION_BITS-1:0] pos_q;

	assign full     = mid_full;
	assign mid_push = push && !mid_full;
	assign mid_pos  = pos_q;

	always_comb begin
		mid_tag.file_byte  = item.file_byte;
		mid_tag.last       = item.last;
		mid_tag.pos_zero   = (pos_q == '0);
		mid_tag.pre_valid  = (pos_q >= POSITION_BITS'(2)) && (pos_q <= POSITION_BITS'(9));
		mid_tag.pre_idx    = pos_q[2:0] - 3'd2;
		mid_tag.pre_end    = (pos_q >= POSITION_BITS'(9));
		mid_tag.short_file = (pos_q < POSITION_BITS'(9));
	end

	// The position saturates at its largest value and restarts with each file.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (mid_push) begin
			if (item.last) begin
				pos_q <= '0;
			end else if (pos_q != '1) begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/ihpp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ihpp_back #(
	parameter int POSITION_BITS = ihpp_pkg::POSITION_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     mid_empty,
	output logic                          mid_pop,
	input  wire ihpp_pkg::tag_t           mid_tag,
	input  wire logic [POSITION_BITS-1:0] mid_pos,
	input  wire logic                     res_full,
	output logic                          res_push,
	output ihpp_pkg::out_t                res_data
);

	localparam int LEN_W = POSITION_BITS + 1;
	localparam bit FULL_WIDTH = (POSITION_BITS == 64);
	localparam logic [63:0] POS_MASK = 64'hFFFF_FFFF_FFFF_FFFF >> (64 - POSITION_BITS);

	ihpp_pkg::phase_t phase_q, phase_d;
	logic        magic_q, magic_d;
	logic [63:0] off_q, off_d;
	logic [5:0]  cand_q, cand_d;
	logic [4:0]  kidx_q, kidx_d;
	logic [31:0] val_q, val_d;
	logic [1:0]  vcnt_q, vcnt_d;
	logic [2:0]  match_q, match_d;
	logic [31:0] height_q, height_d;
	logic [31:0] width_q, width_d;
	logic [31:0] fmt_q, fmt_d;
	logic [31:0] size_q, size_d;
	logic [31:0] type_q, type_d;
	logic        comp_q, comp_d;

	logic             take;
	logic             pos_reached;
	logic [LEN_W-1:0] len;
	logic             off_big;
	logic             off_gt;

	assign take        = !mid_empty && (!mid_tag.last || !res_full);
	assign mid_pop     = take;
	assign res_push    = take && mid_tag.last;
	assign pos_reached = (64'(mid_pos) >= off_q);

	always_comb begin : next_phase
		phase_d = phase_q;
		case (phase_q)
			ihpp_pkg::PH_MAGIC: begin
				if (!mid_tag.pos_zero) begin
					phase_d = magic_d ? ihpp_pkg::PH_OFFSET : ihpp_pkg::PH_SKIP;
				end
			end
			ihpp_pkg::PH_OFFSET: begin
				if (mid_tag.pre_end) begin
					phase_d = ihpp_pkg::PH_TYPE;
				end
			end
			ihpp_pkg::PH_TYPE: begin
				if (pos_reached) begin
					phase_d = ihpp_pkg::PH_SKIP;
				end else if (mid_tag.file_byte == ihpp_pkg::TYPE_KEYED) begin
					phase_d = ihpp_pkg::PH_KEY;
				end
			end
			ihpp_pkg::PH_KEY: begin
				if (mid_tag.file_byte == ihpp_pkg::KEY_NUL) begin
					phase_d = ihpp_pkg::PH_VALUE;
				end
			end
			ihpp_pkg::PH_VALUE: begin
				if (vcnt_q == 2'd3) begin
					phase_d = ihpp_pkg::PH_TYPE;
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	always_comb begin : datapath
		magic_d  = magic_q;
		off_d    = off_q;
		cand_d   = cand_q;
		kidx_d   = kidx_q;
		val_d    = val_q;
		vcnt_d   = vcnt_q;
		match_d  = match_q;
		height_d = height_q;
		width_d  = width_q;
		fmt_d    = fmt_q;
		size_d   = size_q;
		type_d   = type_q;
		comp_d   = comp_q;
		case (phase_q)
			ihpp_pkg::PH_MAGIC: begin
				if (mid_tag.pos_zero) begin
					magic_d = (mid_tag.file_byte == ihpp_pkg::MAGIC_LO);
				end else begin
					magic_d = magic_q && (mid_tag.file_byte == ihpp_pkg::MAGIC_HI);
				end
			end
			ihpp_pkg::PH_OFFSET: begin
				if (mid_tag.pre_valid) begin
					off_d = off_q | (64'(mid_tag.file_byte) << {mid_tag.pre_idx, 3'b000});
				end
			end
			ihpp_pkg::PH_TYPE: begin
				if (!pos_reached && mid_tag.file_byte == ihpp_pkg::TYPE_KEYED) begin
					cand_d  = '1;
					kidx_d  = '0;
					match_d = ihpp_pkg::KEY_NONE;
				end
			end
			ihpp_pkg::PH_KEY: begin
				if (mid_tag.file_byte == ihpp_pkg::KEY_NUL) begin
					// A later table entry wins when several lengths fit.
					match_d = ihpp_pkg::KEY_NONE;
					for (int k = 0; k < ihpp_pkg::KEY_COUNT; k++) begin
						if (cand_q[k] && ihpp_pkg::KEY_LEN[k] == kidx_q) begin
							match_d = 3'(k + 1);
						end
					end
					val_d  = '0;
					vcnt_d = '0;
				end else begin
					for (int k = 0; k < ihpp_pkg::KEY_COUNT; k++) begin
						if (!(kidx_q < ihpp_pkg::KEY_LEN[k] &&
						      ihpp_pkg::KEY_TEXT[k][kidx_q[3:0]] == mid_tag.file_byte)) begin
							cand_d[k] = 1'b0;
						end
					end
					if (kidx_q != ihpp_pkg::KEY_IDX_MAX) begin
						kidx_d = kidx_q + 1'b1;
					end
				end
			end
			ihpp_pkg::PH_VALUE: begin
				val_d = val_q | (32'(mid_tag.file_byte) << {vcnt_q, 3'b000});
				if (vcnt_q == 2'd3) begin
					vcnt_d = '0;
					case (match_q)
						ihpp_pkg::KEY_HEIGHT: begin
							height_d = val_d;
						end
						ihpp_pkg::KEY_WIDTH: begin
							width_d = val_d;
						end
						ihpp_pkg::KEY_COMP_FORMAT: begin
							fmt_d  = val_d;
							comp_d = 1'b1;
						end
						ihpp_pkg::KEY_SIZE: begin
							size_d = val_d;
						end
						ihpp_pkg::KEY_FORMAT: begin
							fmt_d  = val_d;
							comp_d = 1'b0;
						end
						ihpp_pkg::KEY_TYPE: begin
							type_d = val_d;
						end
						default: begin
							comp_d = comp_q;
						end
					endcase
				end else begin
					vcnt_d = vcnt_q + 1'b1;
				end
			end
			default: begin
				magic_d = magic_q;
			end
		endcase
	end

	// File length on the last byte; it saturates only with a full 64-bit position.
	always_comb begin
		if (FULL_WIDTH && (&mid_pos)) begin
			len = LEN_W'(mid_pos);
		end else begin
			len = LEN_W'(mid_pos) + 1'b1;
		end
		off_big = |(off_d & ~POS_MASK);
		off_gt  = ({1'b0, off_d} > 65'(len));
	end

	always_comb begin : result
		res_data = '0;
		if (!mid_tag.pos_zero && !magic_d) begin
			res_data.status = ihpp_pkg::ST_BAD_MAGIC;
		end else if (mid_tag.short_file) begin
			res_data.status = ihpp_pkg::ST_SHORT;
		end else begin
			res_data.image_width     = width_d;
			res_data.image_height    = height_d;
			res_data.pixel_format    = fmt_d;
			res_data.is_compressed   = comp_d;
			res_data.compressed_size = size_d;
			res_data.component_type  = type_d;
			res_data.data_offset     = off_d[31:0];
			if (off_big || off_gt) begin
				res_data.status = ihpp_pkg::ST_BEYOND;
			end else begin
				res_data.status    = ihpp_pkg::ST_OK;
				res_data.data_size = 32'(len) - off_d[31:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= ihpp_pkg::PH_MAGIC;
			magic_q  <= 1'b0;
			off_q    <= '0;
			cand_q   <= '1;
			kidx_q   <= '0;
			val_q    <= '0;
			vcnt_q   <= '0;
			match_q  <= ihpp_pkg::KEY_NONE;
			height_q <= '0;
			width_q  <= '0;
			fmt_q    <= '0;
			size_q   <= '0;
			type_q   <= '0;
			comp_q   <= 1'b0;
		end else if (take) begin
			if (mid_tag.last) begin
				phase_q  <= ihpp_pkg::PH_MAGIC;
				magic_q  <= 1'b0;
				off_q    <= '0;
				cand_q   <= '1;
				kidx_q   <= '0;
				val_q    <= '0;
				vcnt_q   <= '0;
				match_q  <= ihpp_pkg::KEY_NONE;
				height_q <= '0;
				width_q  <= '0;
				fmt_q    <= '0;
				size_q   <= '0;
				type_q   <= '0;
				comp_q   <= 1'b0;
			end else begin
				phase_q  <= phase_d;
				magic_q  <= magic_d;
				off_q    <= off_d;
				cand_q   <= cand_d;
				kidx_q   <= kidx_d;
				val_q    <= val_d;
				vcnt_q   <= vcnt_d;
				match_q  <= match_d;
				height_q <= height_d;
				width_q  <= width_d;
				fmt_q    <= fmt_d;
				size_q   <= size_d;
				type_q   <= type_d;
				comp_q   <= comp_d;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/image_header_property_parser_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Raw image header parser. Feed the file one byte per transfer on item, with
// item.last set on the final byte; each file yields exactly one result transfer
// carrying the status, the width, height, format, size and type properties,
// the data offset and the data size, after which the block is ready for the
// next file with no gap. One byte is taken every clock cycle while the middle
// queue is not full: a classifier tags each byte with its position and hands
// it through a small queue to the parser, which consumes one tagged byte per
// cycle unless a last byte waits on a full result queue, so the sustained
// rate is set by that single parser step. Each byte passes through the middle
// queue, and each result waits in a two-entry result queue; the input keeps
// flowing while results wait, and only stalls once both the result queue and
// the middle queue are full. There is no initialization pass after reset.
module image_header_property_parser_top #(
	parameter int POSITION_BITS = ihpp_pkg::POSITION_BITS_DEF,
	parameter int MID_DEPTH = ihpp_pkg::MID_DEPTH_DEF
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           push,
	output logic                full,
	input  wire ihpp_pkg::in_t  item,
	output logic                empty,
	input  wire logic           pop,
	output ihpp_pkg::out_t      result
);

	localparam int TAG_W = $bits(ihpp_pkg::tag_t);
	localparam int MID_W = TAG_W + POSITION_BITS;
	localparam int RES_W = $bits(ihpp_pkg::out_t);

	// Front side: position counter and byte classification.
	logic                     mid_push;
	logic                     mid_full;
	ihpp_pkg::tag_t           front_tag;
	logic [POSITION_BITS-1:0] front_pos;

	// Back side: tagged bytes leaving the middle queue.
	logic                     mid_pop;
	logic                     mid_empty;
	logic [MID_W-1:0]         mid_rd;
	ihpp_pkg::tag_t           back_tag;
	logic [POSITION_BITS-1:0] back_pos;

	// Results from the parser into the result queue.
	logic                     res_push;
	logic                     res_full;
	ihpp_pkg::out_t           res_data;
	logic [RES_W-1:0]         res_rd;

	ihpp_front #(
		.POSITION_BITS(POSITION_BITS)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.item     (item),
		.mid_full (mid_full),
		.mid_push (mid_push),
		.mid_tag  (front_tag),
		.mid_pos  (front_pos)
	);

	ihpp_fifo #(
		.WIDTH(MID_W),
		.DEPTH(MID_DEPTH)
	) u_mid_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (mid_push),
		.full    (mid_full),
		.wr_data ({front_tag, front_pos}),
		.pop     (mid_pop),
		.empty   (mid_empty),
		.rd_data (mid_rd)
	);

	assign back_tag = ihpp_pkg::tag_t'(mid_rd[MID_W-1:POSITION_BITS]);
	assign back_pos = mid_rd[POSITION_BITS-1:0];

	ihpp_back #(
		.POSITION_BITS(POSITION_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.mid_empty (mid_empty),
		.mid_pop   (mid_pop),
		.mid_tag   (back_tag),
		.mid_pos   (back_pos),
		.res_full  (res_full),
		.res_push  (res_push),
		.res_data  (res_data)
	);

	ihpp_fifo #(
		.WIDTH(RES_W),
		.DEPTH(ihpp_pkg::RES_DEPTH)
	) u_res_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (res_push),
		.full    (res_full),
		.wr_data (res_data),
		.pop     (pop),
		.empty   (empty),
		.rd_data (res_rd)
	);

	assign result = ihpp_pkg::out_t'(res_rd);

`ifndef SYNTH
	// The parser only consumes a byte that is really waiting.
	a_mid_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		mid_pop |-> !mid_empty)
		else $error("parser consumed from an empty middle queue");

	// A result is produced only for the last byte of a file, and never into a full queue.
	a_res_push_last: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> (back_tag.last && !res_full))
		else $error("result transfer without a last byte or into a full queue");

	// A bad magic result carries no offset or size.
	a_bad_magic_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.status == ihpp_pkg::ST_BAD_MAGIC) |->
		(res_data.data_offset == '0 && res_data.data_size == '0))
		else $error("bad magic result carries offset or size");

	// A flagged offset always reports a zero data size.
	a_beyond_size_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(res_push && res_data.status == ihpp_pkg::ST_BEYOND) |-> (res_data.data_size == '0))
		else $error("offset beyond file reported with nonzero size");
`endif

endmodule

`default_nettype wire
